@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the context ring RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The expression must hold in every cycle outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

@@ src/tcr_pkg.sv @@
// ----------------------------------------------------------------------------
// TLB context ring package
// Sizes, opcodes and the request structures shared by the ring modules.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int SLOTS     = 8;
  localparam int TAG_BITS  = 16;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_IN_W = 3;
  localparam int TAG_IN_W  = 16;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [TAG_BITS-1:0] tag_t;

  typedef enum logic [1:0] {
    OP_ACTIVATE = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NOP      = 2'd3
  } opcode_t;

  // Request to the ring: relink a slot after the active one, optionally
  // making it the new active slot.
  typedef struct packed {
    logic  move;
    logic  set_cur;
    slot_t idx;
  } ring_req_t;

  // Request to the holder store: lookup address and tag, plus the update.
  typedef struct packed {
    logic  write;
    logic  clear;
    slot_t idx;
    tag_t  tag;
  } hold_req_t;

endpackage

@@ src/tlb_context_ring_policy.sv @@
// ----------------------------------------------------------------------------
// TLB context ring policy
// Least-recently-used ordering of address-space slots with holder tracking.
// A request is held in the input register, and its result in the output registers.
// Throughput: one request per cycle; busy is never raised.
// The rate is set by the single registered pass through the ring update.
// Reset (synchronous, rst_n low) restores the initial ring order, makes every
// slot a valid holder of the kernel-only space and sets slot 0 active.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlb_context_ring_policy (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_space_tag,
  output logic        out_valid,
  output logic        out_reload_needed,
  output logic        out_holds,
  output logic [2:0]  out_active_slot,
  output logic [2:0]  out_after_active
);

  logic                                in_q_valid_r;
  tcr_pkg::opcode_t                    in_q_op_r;
  logic [tcr_pkg::SLOT_IN_W-1:0]       in_q_slot_r;
  logic [tcr_pkg::TAG_IN_W-1:0]        in_q_tag_r;
  logic                                out_valid_r;
  logic                                out_reload_r;
  logic                                out_holds_r;
  logic [2:0]                          out_active_r;
  logic [2:0]                          out_after_r;

  logic                                in_range;
  logic                                go;
  logic                                is_act;
  logic                                is_rem;
  logic                                is_qry;
  logic                                match;
  tcr_pkg::ring_req_t                  rreq;
  tcr_pkg::hold_req_t                  hreq;
  tcr_pkg::slot_t                      cur_nxt;
  tcr_pkg::slot_t                      after_nxt;

  assign busy     = 1'b0;
  assign in_range = 32'(in_q_slot_r) < 32'(tcr_pkg::SLOTS);
  assign go       = in_q_valid_r && in_range;
  assign is_act   = go && (in_q_op_r == tcr_pkg::OP_ACTIVATE);
  assign is_rem   = go && (in_q_op_r == tcr_pkg::OP_REMOVE);
  assign is_qry   = go && (in_q_op_r == tcr_pkg::OP_QUERY);

  always_comb begin
    hreq.idx     = tcr_pkg::slot_t'(in_q_slot_r);
    hreq.tag     = tcr_pkg::tag_t'(in_q_tag_r);
    hreq.write   = is_act;
    hreq.clear   = is_rem;
  end

  always_comb begin
    rreq.idx     = tcr_pkg::slot_t'(in_q_slot_r);
    rreq.move    = is_act || (is_rem && match);
    rreq.set_cur = is_act;
  end

  tcr_holder u_holder (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .match (match)
  );

  tcr_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (rreq),
    .cur_nxt   (cur_nxt),
    .after_nxt (after_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_q_valid_r <= start && !busy;
      out_valid_r  <= in_q_valid_r;
    end
    if (start && !busy) begin
      in_q_op_r   <= tcr_pkg::opcode_t'(in_opcode);
      in_q_slot_r <= in_slot;
      in_q_tag_r  <= in_space_tag;
    end
    out_reload_r <= is_act && !match;
    out_holds_r  <= is_qry && match;
    out_active_r <= 3'(cur_nxt);
    out_after_r  <= 3'(after_nxt);
  end

  assign out_valid         = out_valid_r;
  assign out_reload_needed = out_reload_r;
  assign out_holds         = out_holds_r;
  assign out_active_slot   = out_active_r;
  assign out_after_active  = out_after_r;

  `ASSERT_NEXT(a_request_gives_result, clk, rst_n, in_q_valid_r, out_valid_r,
               "Registered request produced no result strobe")
  `ASSERT_IMPLIES(a_flags_exclusive, clk, rst_n, out_valid_r,
                  !(out_reload_r && out_holds_r),
                  "Reload and holds flags raised together")

endmodule

@@ src/tcr_holder.sv @@
// ----------------------------------------------------------------------------
// TLB context holder store
// Per-slot address-space tag and valid bit, with lookup and update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcr_holder (
  input  logic               clk,
  input  logic               rst_n,
  input  tcr_pkg::hold_req_t req,
  output logic               match
);

  tcr_pkg::tag_t              tags_r  [tcr_pkg::SLOTS];
  logic [tcr_pkg::SLOTS-1:0]  valid_r;

  assign match = valid_r[req.idx] && (tags_r[req.idx] == req.tag);

  // A clear request only takes effect when the slot validly holds the tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '1;
      for (int i = 0; i < tcr_pkg::SLOTS; i++) begin
        tags_r[i] <= '0;
      end
    end else if (req.write) begin
      tags_r[req.idx]  <= req.tag;
      valid_r[req.idx] <= 1'b1;
    end else if (req.clear && match) begin
      valid_r[req.idx] <= 1'b0;
    end
  end

  `ASSERT_NEXT(a_write_sets_valid, clk, rst_n, req.write,
               valid_r[$past(req.idx)], "Activated slot is not valid afterwards")

endmodule

@@ src/tcr_ring.sv @@
// ----------------------------------------------------------------------------
// TLB context ring
// Circular doubly linked slot order and the active slot pointer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcr_ring (
  input  logic               clk,
  input  logic               rst_n,
  input  tcr_pkg::ring_req_t req,
  output tcr_pkg::slot_t     cur_nxt,
  output tcr_pkg::slot_t     after_nxt
);

  tcr_pkg::slot_t next_r [tcr_pkg::SLOTS];
  tcr_pkg::slot_t prev_r [tcr_pkg::SLOTS];
  tcr_pkg::slot_t next_nxt [tcr_pkg::SLOTS];
  tcr_pkg::slot_t prev_nxt [tcr_pkg::SLOTS];
  tcr_pkg::slot_t cur_r;
  tcr_pkg::slot_t s_prev;
  tcr_pkg::slot_t s_next;
  tcr_pkg::slot_t c_next;
  logic           relink;

  assign s_prev = prev_r[req.idx];
  assign s_next = next_r[req.idx];
  assign c_next = next_r[cur_r];
  assign relink = req.move && (req.idx != cur_r) && (c_next != req.idx);

  // The six link writes of a relink always hit distinct entries.
  always_comb begin
    for (int i = 0; i < tcr_pkg::SLOTS; i++) begin
      next_nxt[i] = next_r[i];
      prev_nxt[i] = prev_r[i];
      if (relink) begin
        if (tcr_pkg::slot_t'(i) == cur_r) begin
          next_nxt[i] = req.idx;
        end else if (tcr_pkg::slot_t'(i) == req.idx) begin
          next_nxt[i] = c_next;
        end else if (tcr_pkg::slot_t'(i) == s_prev) begin
          next_nxt[i] = s_next;
        end
        if (tcr_pkg::slot_t'(i) == req.idx) begin
          prev_nxt[i] = cur_r;
        end else if (tcr_pkg::slot_t'(i) == c_next) begin
          prev_nxt[i] = req.idx;
        end else if (tcr_pkg::slot_t'(i) == s_next) begin
          prev_nxt[i] = s_prev;
        end
      end
    end
  end

  assign cur_nxt   = req.set_cur ? req.idx : cur_r;
  assign after_nxt = next_nxt[cur_nxt];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      for (int i = 0; i < tcr_pkg::SLOTS; i++) begin
        next_r[i] <= (i == tcr_pkg::SLOTS - 1) ? tcr_pkg::slot_t'(0)
                                               : tcr_pkg::slot_t'(i + 1);
        prev_r[i] <= (i == 0) ? tcr_pkg::slot_t'(tcr_pkg::SLOTS - 1)
                              : tcr_pkg::slot_t'(i - 1);
      end
    end else begin
      cur_r <= cur_nxt;
      for (int i = 0; i < tcr_pkg::SLOTS; i++) begin
        next_r[i] <= next_nxt[i];
        prev_r[i] <= prev_nxt[i];
      end
    end
  end

  `ASSERT_ALWAYS(a_links_agree, clk, rst_n, prev_r[next_r[cur_r]] == cur_r,
                 "Forward and backward links disagree at the active slot")
  `ASSERT_NEXT(a_relink_follows, clk, rst_n, relink,
               next_r[$past(cur_r)] == $past(req.idx),
               "Relinked slot does not follow the previous active slot")

endmodule
